>>> hdl/double_ended_priority_queue_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the double-ended priority queue
// Implication checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define DEPQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define DEPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/depq_pkg.sv
// ----------------------------------------------------------------------------
// depq_pkg
// Shared types and codes for the double-ended priority queue.
// ----------------------------------------------------------------------------
package depq_pkg;

	localparam int CAPACITY = 256;
	localparam int ID_W     = 24;
	localparam int PRIO_W   = 32;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_POPMAX = 2'd1;
	localparam logic [1:0] OP_POPMIN = 2'd2;

	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_REMOVED  = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef struct packed {
		logic signed [PRIO_W-1:0] prio;
		logic [ID_W-1:0]          id;
	} depq_entry_t;

	// broadcast to every cell; at most one of ins/pmax/pmin is set
	typedef struct packed {
		logic        ins;
		logic        pmax;
		logic        pmin;
		depq_entry_t ent;
	} depq_cmd_t;

endpackage

>>> hdl/double_ended_priority_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_priority_queue_top
// Sorted chain of cells holding up to CAPACITY entries, min at cell 0.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------
//   request  | start / busy       | op, item_id, priority_req
//   response | done (strobe)      | result_id, status
//
// One transaction per cycle: busy stays low, the whole chain shifts in the
// cycle a request is taken and the response strobes on the following cycle.
// The max read is a one-hot select over the cells' last-entry flags.
// Reset clears all valid bits; entry payloads are not reset.
// The receiver cannot stall; every request yields exactly one response.
// ----------------------------------------------------------------------------
`include "double_ended_priority_queue_top_assert.svh"

module double_ended_priority_queue_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         op,
	input  logic [depq_pkg::ID_W-1:0]          item_id,
	input  logic signed [depq_pkg::PRIO_W-1:0] priority_req,
	output logic                               done,
	output logic [depq_pkg::ID_W-1:0]          result_id,
	output logic [1:0]                         status
);

	localparam int N = depq_pkg::CAPACITY;

	depq_pkg::depq_entry_t          ent   [N];
	logic [N-1:0]                   vld;
	logic [N-1:0]                   gt;
	logic [depq_pkg::ID_W-1:0]      lid   [N];
	depq_pkg::depq_cmd_t            cmd;
	logic                           accept;
	logic                           full;
	logic                           empty;
	logic [depq_pkg::ID_W-1:0]      max_id;
	logic                           done_q;
	logic [depq_pkg::ID_W-1:0]      result_id_q;
	logic [1:0]                     status_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = vld[N-1];
	assign empty  = !vld[0];

	always_comb begin
		cmd.ins     = accept && (op == depq_pkg::OP_INSERT) && !full;
		cmd.pmax    = accept && (op == depq_pkg::OP_POPMAX) && !empty;
		cmd.pmin    = accept && (op != depq_pkg::OP_INSERT) && (op != depq_pkg::OP_POPMAX)
		              && !empty;
		cmd.ent.prio = priority_req;
		cmd.ent.id   = item_id;
	end

	always_comb begin
		max_id = '0;
		for (int i = 0; i < N; i++) begin
			max_id = max_id | lid[i];
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		depq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.left_ent  ((i == 0) ? depq_pkg::depq_entry_t'('0) : ent[(i == 0) ? 0 : i-1]),
			.left_vld  ((i == 0) ? 1'b0 : vld[(i == 0) ? 0 : i-1]),
			.left_gt   ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i-1]),
			.right_ent ((i == N-1) ? depq_pkg::depq_entry_t'('0) : ent[(i == N-1) ? i : i+1]),
			.right_vld ((i == N-1) ? 1'b0 : vld[(i == N-1) ? i : i+1]),
			.ent       (ent[i]),
			.vld       (vld[i]),
			.gt        (gt[i]),
			.last_id   (lid[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			priority if (op == depq_pkg::OP_INSERT) begin
				result_id_q <= '0;
				status_q    <= full ? depq_pkg::ST_FULL : depq_pkg::ST_INSERTED;
			end else if (empty) begin
				result_id_q <= '0;
				status_q    <= depq_pkg::ST_EMPTY;
			end else if (op == depq_pkg::OP_POPMAX) begin
				result_id_q <= max_id;
				status_q    <= depq_pkg::ST_REMOVED;
			end else begin
				result_id_q <= ent[0].id;
				status_q    <= depq_pkg::ST_REMOVED;
			end
		end
	end

	assign done      = done_q;
	assign result_id = result_id_q;
	assign status    = status_q;

	`DEPQ_ASSERT_NEXT(a_resp_follows, accept, done, "response missing after request")
	`DEPQ_ASSERT_NEXT(a_no_spurious, !accept, !done, "response without request")
	`DEPQ_ASSERT_NOW(a_vld_prefix, 1'b1, ((vld + 1'b1) & vld) == '0, "valid bits not a prefix")
	`DEPQ_ASSERT_NOW(a_full_flag, done && (status == depq_pkg::ST_FULL), $past(vld[N-1]),
		"full drop while chain not full")

endmodule

>>> hdl/depq_cell.sv
// ----------------------------------------------------------------------------
// depq_cell
// One slot of the sorted chain: holds one entry, shifts with its neighbors.
// ----------------------------------------------------------------------------
module depq_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  depq_pkg::depq_cmd_t        cmd,
	input  depq_pkg::depq_entry_t      left_ent,
	input  logic                       left_vld,
	input  logic                       left_gt,
	input  depq_pkg::depq_entry_t      right_ent,
	input  logic                       right_vld,
	output depq_pkg::depq_entry_t      ent,
	output logic                       vld,
	output logic                       gt,
	output logic [depq_pkg::ID_W-1:0]  last_id
);

	depq_pkg::depq_entry_t ent_q;
	logic                  vld_q;

	// empty slots count as greater than any key, so gt is monotonic along the chain
	assign gt      = !vld_q || ($signed(ent_q.prio) > $signed(cmd.ent.prio));
	assign ent     = ent_q;
	assign vld     = vld_q;
	assign last_id = (vld_q && !right_vld) ? ent_q.id : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			if (cmd.ins) begin
				if (gt) begin
					vld_q <= left_gt ? left_vld : 1'b1;
				end
			end else if (cmd.pmin) begin
				vld_q <= right_vld;
			end else if (cmd.pmax) begin
				vld_q <= vld_q && right_vld;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (gt) begin
				ent_q <= left_gt ? left_ent : cmd.ent;
			end
		end else if (cmd.pmin) begin
			ent_q <= right_ent;
		end
	end

endmodule
